[src/vast_pkg.sv]
// types, codes and constants for the voice allocator with stealing
// used by vast_dp, vast_ctrl and voice_allocator_with_stealing_top
package vast_pkg;

  localparam int NUM_VOICES_DEF = 64;
  localparam int MAX_GROUP_DEF  = 6;
  localparam int STEAL_LIMIT    = 100;
  localparam logic [6:0] VOICES_TOTAL_RST = 7'd64;

  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_FREE   = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;
  localparam logic [1:0] CMD_TAG    = 2'd3;

  localparam logic [1:0] RES_OK         = 2'd0;
  localparam logic [1:0] RES_NO_VOICES  = 2'd1;
  localparam logic [1:0] RES_BAD_HANDLE = 2'd2;

  localparam logic [1:0] ST_FREE = 2'd0;
  localparam logic [1:0] ST_PLAY = 2'd1;
  localparam logic [1:0] ST_HELD = 2'd2;

  localparam logic REG_STEAL_EQUAL  = 1'b0;
  localparam logic REG_VOICES_TOTAL = 1'b1;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [2:0]         voices_needed;
    logic [7:0]         priority_req;
    logic [5:0]         range_low;
    logic [6:0]         range_high;
    logic [5:0]         voice_index;
    logic signed [31:0] lookup_handle;
    logic [31:0]        audio_tick;
    logic [15:0]        patch_key;
    logic               master_flag;
  } req_t;

  typedef struct packed {
    logic [1:0]         status_code;
    logic [5:0]         voice_out;
    logic [30:0]        group_handle;
    logic               stop_valid;
    logic signed [31:0] stop_handle;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] stamp;
    logic [7:0]  prio;
    logic [31:0] handle;
    logic        mvalid;
    logic [7:0]  master;
    logic [15:0] patch;
    logic        is_master;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{ST_FREE, 32'd0, 8'd0, 32'd0, 1'b0, 8'd0, 16'd0, 1'b0};

  typedef enum logic [1:0] {SCAN_FREE, SCAN_STEAL, SCAN_COUNT} scan_t;
  typedef enum logic [2:0] {RD_NONE, RD_SCAN, RD_PICK, RD_MASTER, RD_VI, RD_LOOKUP} rd_t;
  typedef enum logic [2:0] {WR_NONE, WR_ALLOC, WR_TAG, WR_REL_V, WR_REL_M, WR_HOLD_M} wr_t;
  typedef enum logic [1:0] {DEC_REL_V, DEC_REL_BOTH, DEC_HOLD} dec_t;

  typedef struct packed {
    logic       load;
    logic       bump;
    logic       scan_init;
    logic       scan_run;
    scan_t      scan_kind;
    logic       push;
    logic       sort_step;
    logic       k_clr;
    logic       k_inc;
    rd_t        rd;
    logic       stop_cap;
    logic       stop_cap_m;
    logic       cap_vent;
    wr_t        wr;
    logic       set_fail;
    logic [1:0] fail_code;
    logic       emit;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] req_cmd;
    logic       need_bad;
    logic       vi_in;
    logic       lookup_in;
    logic       lookup_hit;
    logic       key_zero;
    logic       scan_done;
    logic       best_ok;
    logic       pass_last;
    logic       need_met;
    logic       k_last;
    logic       sort_last;
    logic       stop_master;
    logic       single;
    logic       can_emit;
    dec_t       dec;
  } dp_stat_t;

endpackage

[src/voice_allocator_with_stealing_top.sv]
// allocate scans the voice range once per needed voice and once per stolen voice, sorts
//   the picked voices, reads each stop handle (via the master for a stolen voice whose
//   handle needs it) and writes each voice; free with a nonzero patch key scans
//   voices_total voices; scans read one voice per cycle; words leave via the output register
// throughput: one command at a time; the next is taken while the last word waits
// reset: synchronous, clears control state and the per-voice valid bits at once
module voice_allocator_with_stealing_top #(
  parameter int NUM_VOICES = vast_pkg::NUM_VOICES_DEF,
  parameter int MAX_GROUP  = vast_pkg::MAX_GROUP_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  vast_pkg::req_t req_data,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output vast_pkg::rsp_t rsp_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  logic steal_equal;
  logic [6:0] voices_total;
  vast_pkg::dp_cmd_t dp_cmd;
  vast_pkg::dp_stat_t dp_stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      steal_equal <= 1'b0;
      voices_total <= vast_pkg::VOICES_TOTAL_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        vast_pkg::REG_STEAL_EQUAL:  steal_equal <= pwdata[0];
        vast_pkg::REG_VOICES_TOTAL: voices_total <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      vast_pkg::REG_STEAL_EQUAL:  prdata = {31'd0, steal_equal};
      vast_pkg::REG_VOICES_TOTAL: prdata = {25'd0, voices_total};
      default:                    prdata = '0;
    endcase
  end

  vast_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .cmd       (dp_cmd),
    .stat      (dp_stat)
  );

  vast_dp #(
    .NUM_VOICES (NUM_VOICES),
    .MAX_GROUP  (MAX_GROUP)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (dp_cmd),
    .stat         (dp_stat),
    .steal_equal  (steal_equal),
    .voices_total (voices_total),
    .req_data     (req_data),
    .rsp_data     (rsp_data),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready)
  );

endmodule

[src/vast_dp.sv]
// datapath: voice table memory, scan and pick registers, stop capture, output word
// depends on vast_pkg; driven by vast_ctrl
module vast_dp #(
  parameter int NUM_VOICES = vast_pkg::NUM_VOICES_DEF,
  parameter int MAX_GROUP  = vast_pkg::MAX_GROUP_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  vast_pkg::dp_cmd_t  cmd,
  output vast_pkg::dp_stat_t stat,
  input  logic               steal_equal,
  input  logic [6:0]         voices_total,
  input  vast_pkg::req_t     req_data,
  output vast_pkg::rsp_t     rsp_data,
  output logic               rsp_valid,
  input  logic               rsp_ready
);

  localparam int IW = $clog2(NUM_VOICES);
  localparam int CW = ($clog2(NUM_VOICES + 1) > 7) ? $clog2(NUM_VOICES + 1) : 7;
  localparam int GW = $clog2(MAX_GROUP + 1);
  localparam int KW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

  vast_pkg::req_t rq;
  logic [22:0] hcnt;
  logic [IW-1:0] picked [MAX_GROUP];
  logic [IW-1:0] picked_next [MAX_GROUP];
  logic [GW-1:0] count, pass, k;
  logic [IW-1:0] best;
  logic best_ok;
  logic [31:0] bt;
  logic signed [9:0] thr;
  logic [CW-1:0] scan, bound;
  logic p_vld;
  logic [IW-1:0] p_addr;
  logic [31:0] stops [MAX_GROUP];
  logic [MAX_GROUP-1:0] stopv;
  logic [CW-1:0] n;
  logic [IW-1:0] mv;
  logic mv_ok;
  vast_pkg::entry_t ment, vent;
  logic [7:0] mst;
  logic single;
  logic [1:0] s_code;
  logic [5:0] s_voice;
  vast_pkg::rsp_t obuf;
  logic ovalid;

  vast_pkg::entry_t mem [NUM_VOICES];
  logic [NUM_VOICES-1:0] vld;
  vast_pkg::entry_t rraw, rent, wdata;
  logic rvld;
  logic [IW-1:0] raddr, waddr;
  logic we;

  logic [CW-1:0] hi_c, tot_c, vi_c, pv_c;
  logic [IW-1:0] vi_a;
  logic [KW-1:0] kk;
  logic [GW-1:0] need_g;
  logic is_picked;
  logic [MAX_GROUP-1:0] sw;
  logic [30:0] grp;
  logic signed [9:0] p_s;
  logic [31:0] h_u;

  assign hi_c = (CW'(rq.range_high) > CW'(NUM_VOICES)) ? CW'(NUM_VOICES) : CW'(rq.range_high);
  assign tot_c = (CW'(voices_total) > CW'(NUM_VOICES)) ? CW'(NUM_VOICES) : CW'(voices_total);
  assign vi_c = CW'(rq.voice_index);
  assign vi_a = vi_c[IW-1:0];
  assign kk = k[KW-1:0];
  assign need_g = GW'(rq.voices_needed);
  assign pv_c = CW'(picked[kk]);
  assign grp = {hcnt, 8'(picked[0])};
  assign rent = rvld ? rraw : vast_pkg::ENTRY_RESET;
  assign p_s = $signed({2'b00, rent.prio});
  assign h_u = $unsigned(rq.lookup_handle);

  always_comb begin
    is_picked = 1'b0;
    for (int j = 0; j < MAX_GROUP; j++) begin
      if (GW'(j) < count && picked[j] == p_addr) is_picked = 1'b1;
    end
  end

  // odd-even transposition step over the picked list
  always_comb begin
    sw = '0;
    for (int i = 0; i + 1 < MAX_GROUP; i++) begin
      sw[i] = ((i % 2) == int'(k[0])) && (GW'(i + 1) < count) && (picked[i] > picked[i+1]);
    end
    for (int i = 0; i < MAX_GROUP; i++) begin
      picked_next[i] = picked[i];
      if (i + 1 < MAX_GROUP && sw[i]) picked_next[i] = picked[i+1];
      if (i > 0 && sw[i-1]) picked_next[i] = picked[i-1];
    end
  end

  always_comb begin
    case (cmd.rd)
      vast_pkg::RD_SCAN:   raddr = scan[IW-1:0];
      vast_pkg::RD_PICK:   raddr = picked[kk];
      vast_pkg::RD_MASTER: raddr = mst[IW-1:0];
      vast_pkg::RD_VI:     raddr = vi_a;
      vast_pkg::RD_LOOKUP: raddr = h_u[IW-1:0];
      default:             raddr = scan[IW-1:0];
    endcase
  end

  always_comb begin
    we = 1'b1;
    waddr = vi_a;
    wdata = vent;
    case (cmd.wr)
      vast_pkg::WR_ALLOC: begin
        waddr = picked[kk];
        wdata = rent;
        wdata.status = vast_pkg::ST_PLAY;
        wdata.stamp = rq.audio_tick;
        wdata.prio = rq.priority_req;
        wdata.handle = (k == '0) ? {1'b0, grp} : 32'hFFFF_FFFF;
        wdata.mvalid = (k != '0);
        wdata.master = 8'(picked[0]);
      end
      vast_pkg::WR_TAG: begin
        wdata = rent;
        wdata.patch = rq.patch_key;
        wdata.is_master = rq.master_flag;
      end
      vast_pkg::WR_REL_V: begin
        wdata = vent;
        wdata.status = vast_pkg::ST_FREE;
        wdata.patch = '0;
        wdata.is_master = 1'b0;
        wdata.stamp = rq.audio_tick;
      end
      vast_pkg::WR_REL_M: begin
        waddr = mv;
        wdata = ment;
        wdata.status = vast_pkg::ST_FREE;
        wdata.patch = '0;
        wdata.is_master = 1'b0;
        wdata.stamp = rq.audio_tick;
      end
      vast_pkg::WR_HOLD_M: begin
        waddr = mv;
        wdata = ment;
        wdata.status = vast_pkg::ST_HELD;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rraw <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      rvld <= 1'b0;
    end else begin
      if (we) vld[waddr] <= 1'b1;
      rvld <= vld[raddr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hcnt <= '0;
      count <= '0;
      pass <= '0;
      k <= '0;
      p_vld <= 1'b0;
      single <= 1'b1;
      ovalid <= 1'b0;
    end else begin
      if (cmd.load) begin
        count <= '0;
        pass <= '0;
        k <= '0;
        single <= (req_data.cmd != vast_pkg::CMD_ALLOC);
      end
      if (cmd.bump) hcnt <= hcnt + 23'd1;
      if (cmd.scan_init) p_vld <= 1'b0;
      if (cmd.scan_run) p_vld <= (scan < bound);
      if (cmd.push) begin
        pass <= pass + GW'(1);
        if (best_ok) count <= count + GW'(1);
      end
      if (cmd.k_clr) k <= '0;
      else if (cmd.k_inc) k <= k + GW'(1);
      if (cmd.set_fail) single <= 1'b1;
      if (cmd.emit) ovalid <= 1'b1;
      else if (rsp_ready) ovalid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rq <= req_data;
      s_code <= vast_pkg::RES_OK;
      s_voice <= (req_data.cmd == vast_pkg::CMD_LOOKUP) ?
                 req_data.lookup_handle[5:0] : req_data.voice_index;
    end
    if (cmd.set_fail) begin
      s_code <= cmd.fail_code;
      s_voice <= '0;
    end
    if (cmd.scan_init) begin
      scan <= (cmd.scan_kind == vast_pkg::SCAN_COUNT) ? '0 : CW'(rq.range_low);
      bound <= (cmd.scan_kind == vast_pkg::SCAN_COUNT) ? tot_c : hi_c;
      best_ok <= 1'b0;
      bt <= 32'hFFFF_FFFF;
      thr <= steal_equal ? $signed({2'b00, rq.priority_req}) :
             $signed({2'b00, rq.priority_req}) - 10'sd1;
      n <= '0;
      mv_ok <= 1'b0;
    end
    if (cmd.scan_run) begin
      if (scan < bound) scan <= scan + CW'(1);
      p_addr <= scan[IW-1:0];
      if (p_vld) begin
        case (cmd.scan_kind)
          vast_pkg::SCAN_FREE: begin
            if (rent.status == vast_pkg::ST_FREE && !is_picked && rent.stamp < bt) begin
              bt <= rent.stamp;
              best <= p_addr;
              best_ok <= 1'b1;
            end
          end
          vast_pkg::SCAN_STEAL: begin
            if (!is_picked && rent.prio <= 8'(vast_pkg::STEAL_LIMIT)) begin
              if (p_s < thr) begin
                thr <= p_s;
                bt <= rent.stamp;
                best <= p_addr;
                best_ok <= 1'b1;
              end else if (p_s == thr && rent.stamp < bt) begin
                bt <= rent.stamp;
                best <= p_addr;
                best_ok <= 1'b1;
              end
            end
          end
          vast_pkg::SCAN_COUNT: begin
            if (rent.patch == vent.patch && !rent.handle[31] &&
                rent.status != vast_pkg::ST_FREE) begin
              n <= n + CW'(1);
              if (rent.is_master) begin
                mv <= p_addr;
                ment <= rent;
                mv_ok <= 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
    end
    if (cmd.push && best_ok) picked[count[KW-1:0]] <= best;
    if (cmd.sort_step) picked <= picked_next;
    if (cmd.stop_cap) begin
      stopv[kk] <= (rent.status != vast_pkg::ST_FREE);
      stops[kk] <= (rent.status != vast_pkg::ST_FREE) ? rent.handle : 32'd0;
      mst <= rent.master;
    end
    if (cmd.stop_cap_m) stops[kk] <= rent.handle;
    if (cmd.cap_vent) vent <= rent;
    if (cmd.emit) begin
      if (single) begin
        obuf <= '{s_code, s_voice, 31'd0, 1'b0, 32'sd0, 1'b1};
      end else begin
        obuf <= '{vast_pkg::RES_OK, pv_c[5:0], grp, stopv[kk], $signed(stops[kk]),
                  stat.k_last};
      end
    end
  end

  always_comb begin
    stat.req_cmd = req_data.cmd;
    stat.need_bad = (rq.voices_needed == 3'd0) ||
                    (8'(rq.voices_needed) > 8'(MAX_GROUP));
    stat.vi_in = vi_c < CW'(NUM_VOICES);
    stat.lookup_in = !h_u[31] && ({1'b0, h_u[7:0]} < 9'(tot_c));
    stat.lookup_hit = (rent.status != vast_pkg::ST_FREE) && (rent.handle == h_u);
    stat.key_zero = (vent.patch == 16'd0);
    stat.scan_done = !(scan < bound) && !p_vld;
    stat.best_ok = best_ok;
    stat.pass_last = (pass + GW'(1)) == need_g;
    stat.need_met = (count == need_g);
    stat.k_last = (k + GW'(1)) == need_g;
    stat.sort_last = (k == GW'(MAX_GROUP - 1));
    stat.stop_master = (rent.status != vast_pkg::ST_FREE) && rent.handle[31] && rent.mvalid;
    stat.single = single;
    stat.can_emit = !ovalid || rsp_ready;
    if (n == CW'(1)) stat.dec = vast_pkg::DEC_REL_V;
    else if (mv_ok && ment.status == vast_pkg::ST_HELD && mv != vi_a && n == CW'(2))
      stat.dec = vast_pkg::DEC_REL_BOTH;
    else if (mv_ok && ment.status == vast_pkg::ST_PLAY && mv == vi_a)
      stat.dec = vast_pkg::DEC_HOLD;
    else stat.dec = vast_pkg::DEC_REL_V;
  end

  assign rsp_data = obuf;
  assign rsp_valid = ovalid;

endmodule

[src/vast_ctrl.sv]
// controller state machine sequencing allocate, free, look up and tag
// depends on vast_pkg; drives vast_dp through command and status structs
module vast_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  output vast_pkg::dp_cmd_t  cmd,
  input  vast_pkg::dp_stat_t stat
);

  typedef enum logic [29:0] {
    S_IDLE   = 30'h0000_0001, S_ACHK   = 30'h0000_0002, S_FINIT  = 30'h0000_0004,
    S_FSCAN  = 30'h0000_0008, S_FPUSH  = 30'h0000_0010, S_SCHK   = 30'h0000_0020,
    S_SINIT  = 30'h0000_0040, S_SSCAN  = 30'h0000_0080, S_SPUSH  = 30'h0000_0100,
    S_SORT   = 30'h0000_0200, S_STRD   = 30'h0000_0400, S_STWT   = 30'h0000_0800,
    S_SMRD   = 30'h0000_1000, S_SMWT   = 30'h0000_2000, S_WRRD   = 30'h0000_4000,
    S_WR     = 30'h0000_8000, S_FRRD   = 30'h0001_0000, S_FRWT   = 30'h0002_0000,
    S_FRCHK  = 30'h0004_0000, S_FRSCAN = 30'h0008_0000, S_FRDEC  = 30'h0010_0000,
    S_RELV   = 30'h0020_0000, S_RELV2  = 30'h0040_0000, S_RELM   = 30'h0080_0000,
    S_HOLD   = 30'h0100_0000, S_LRD    = 30'h0200_0000, S_LWT    = 30'h0400_0000,
    S_TRD    = 30'h0800_0000, S_TWR    = 30'h1000_0000, S_EMIT   = 30'h2000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    req_ready = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load = 1'b1;
          case (stat.req_cmd)
            vast_pkg::CMD_ALLOC:  state_next = S_ACHK;
            vast_pkg::CMD_FREE:   state_next = S_FRRD;
            vast_pkg::CMD_LOOKUP: state_next = S_LRD;
            default:              state_next = S_TRD;
          endcase
        end
      end
      S_ACHK: begin
        cmd.bump = 1'b1;
        if (stat.need_bad) begin
          cmd.set_fail = 1'b1;
          cmd.fail_code = vast_pkg::RES_NO_VOICES;
          state_next = S_EMIT;
        end else state_next = S_FINIT;
      end
      S_FINIT: begin
        cmd.scan_init = 1'b1;
        cmd.scan_kind = vast_pkg::SCAN_FREE;
        state_next = S_FSCAN;
      end
      S_FSCAN: begin
        cmd.scan_run = 1'b1;
        cmd.scan_kind = vast_pkg::SCAN_FREE;
        cmd.rd = vast_pkg::RD_SCAN;
        if (stat.scan_done) state_next = S_FPUSH;
      end
      S_FPUSH: begin
        cmd.push = 1'b1;
        state_next = stat.pass_last ? S_SCHK : S_FINIT;
      end
      S_SCHK: begin
        if (stat.need_met) begin
          cmd.k_clr = 1'b1;
          state_next = S_SORT;
        end else state_next = S_SINIT;
      end
      S_SINIT: begin
        cmd.scan_init = 1'b1;
        cmd.scan_kind = vast_pkg::SCAN_STEAL;
        state_next = S_SSCAN;
      end
      S_SSCAN: begin
        cmd.scan_run = 1'b1;
        cmd.scan_kind = vast_pkg::SCAN_STEAL;
        cmd.rd = vast_pkg::RD_SCAN;
        if (stat.scan_done) state_next = S_SPUSH;
      end
      S_SPUSH: begin
        if (!stat.best_ok) begin
          cmd.set_fail = 1'b1;
          cmd.fail_code = vast_pkg::RES_NO_VOICES;
          state_next = S_EMIT;
        end else begin
          cmd.push = 1'b1;
          state_next = S_SCHK;
        end
      end
      S_SORT: begin
        cmd.sort_step = 1'b1;
        if (stat.sort_last) begin
          cmd.k_clr = 1'b1;
          state_next = S_STRD;
        end else cmd.k_inc = 1'b1;
      end
      S_STRD: begin
        cmd.rd = vast_pkg::RD_PICK;
        state_next = S_STWT;
      end
      S_STWT, S_SMWT: begin
        if (state == S_STWT) cmd.stop_cap = 1'b1;
        else cmd.stop_cap_m = 1'b1;
        if (state == S_STWT && stat.stop_master) state_next = S_SMRD;
        else if (stat.k_last) begin
          cmd.k_clr = 1'b1;
          state_next = S_WRRD;
        end else begin
          cmd.k_inc = 1'b1;
          state_next = S_STRD;
        end
      end
      S_SMRD: begin
        cmd.rd = vast_pkg::RD_MASTER;
        state_next = S_SMWT;
      end
      S_WRRD: begin
        cmd.rd = vast_pkg::RD_PICK;
        state_next = S_WR;
      end
      S_WR: begin
        cmd.wr = vast_pkg::WR_ALLOC;
        if (stat.k_last) begin
          cmd.k_clr = 1'b1;
          state_next = S_EMIT;
        end else begin
          cmd.k_inc = 1'b1;
          state_next = S_WRRD;
        end
      end
      S_FRRD: begin
        if (!stat.vi_in) state_next = S_EMIT;
        else begin
          cmd.rd = vast_pkg::RD_VI;
          state_next = S_FRWT;
        end
      end
      S_FRWT: begin
        cmd.cap_vent = 1'b1;
        state_next = S_FRCHK;
      end
      S_FRCHK: begin
        if (stat.key_zero) state_next = S_RELV;
        else begin
          cmd.scan_init = 1'b1;
          cmd.scan_kind = vast_pkg::SCAN_COUNT;
          state_next = S_FRSCAN;
        end
      end
      S_FRSCAN: begin
        cmd.scan_run = 1'b1;
        cmd.scan_kind = vast_pkg::SCAN_COUNT;
        cmd.rd = vast_pkg::RD_SCAN;
        if (stat.scan_done) state_next = S_FRDEC;
      end
      S_FRDEC: begin
        case (stat.dec)
          vast_pkg::DEC_REL_BOTH: state_next = S_RELV2;
          vast_pkg::DEC_HOLD:     state_next = S_HOLD;
          default:                state_next = S_RELV;
        endcase
      end
      S_RELV: begin
        cmd.wr = vast_pkg::WR_REL_V;
        state_next = S_EMIT;
      end
      S_RELV2: begin
        cmd.wr = vast_pkg::WR_REL_V;
        state_next = S_RELM;
      end
      S_RELM: begin
        cmd.wr = vast_pkg::WR_REL_M;
        state_next = S_EMIT;
      end
      S_HOLD: begin
        cmd.wr = vast_pkg::WR_HOLD_M;
        state_next = S_EMIT;
      end
      S_LRD: begin
        if (!stat.lookup_in) begin
          cmd.set_fail = 1'b1;
          cmd.fail_code = vast_pkg::RES_BAD_HANDLE;
          state_next = S_EMIT;
        end else begin
          cmd.rd = vast_pkg::RD_LOOKUP;
          state_next = S_LWT;
        end
      end
      S_LWT: begin
        if (!stat.lookup_hit) begin
          cmd.set_fail = 1'b1;
          cmd.fail_code = vast_pkg::RES_BAD_HANDLE;
        end
        state_next = S_EMIT;
      end
      S_TRD: begin
        if (!stat.vi_in) state_next = S_EMIT;
        else begin
          cmd.rd = vast_pkg::RD_VI;
          state_next = S_TWR;
        end
      end
      S_TWR: begin
        cmd.wr = vast_pkg::WR_TAG;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.can_emit) begin
          cmd.emit = 1'b1;
          if (stat.single || stat.k_last) state_next = S_IDLE;
          else cmd.k_inc = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[verif/voice_allocator_with_stealing_top_tb.sv]
// testbench for voice_allocator_with_stealing_top: predicts every result word from
// its own copy of the voice table and checks the words in order; depends on vast_pkg
`timescale 1ns / 1ps

module voice_allocator_with_stealing_top_tb;

  localparam int NV = 64;
  localparam int MG = 6;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  vast_pkg::req_t req_data = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  vast_pkg::rsp_t rsp_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  voice_allocator_with_stealing_top dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // shadow voice table
  logic [1:0]  v_status [NV];
  logic [31:0] v_stamp [NV];
  logic [7:0]  v_prio [NV];
  logic [31:0] v_handle [NV];
  int          v_master [NV];
  logic [15:0] v_patch [NV];
  logic        v_is_master [NV];
  logic [22:0] group_count;
  logic        cfg_steal_equal;
  logic [6:0]  cfg_voices_total;

  vast_pkg::req_t pending_words [$];
  vast_pkg::rsp_t expected_words [$];
  logic [31:0] live_handles [$];
  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;
  logic hold_go = 1'b0;
  int mismatches = 0;
  int cycles = 0;
  logic [31:0] tick_now = 32'd10;

  function automatic vast_pkg::rsp_t make_word(logic [1:0] st, logic [5:0] v, logic [30:0] g,
                                               logic sv, logic [31:0] sh, logic lst);
    vast_pkg::rsp_t w;
    w.status_code = st;
    w.voice_out = v;
    w.group_handle = g;
    w.stop_valid = sv;
    w.stop_handle = sh;
    w.last = lst;
    return w;
  endfunction

  function automatic bit in_list(int lst[MG], int cnt, int v);
    for (int k = 0; k < cnt; k++)
      if (lst[k] == v) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void release_voice(int v, logic [31:0] tk);
    v_status[v] = vast_pkg::ST_FREE;
    v_patch[v] = '0;
    v_is_master[v] = 1'b0;
    v_stamp[v] = tk;
  endfunction

  function automatic void predict_alloc(vast_pkg::req_t r);
    int pk [MG];
    logic stopv [MG];
    logic [31:0] stoph [MG];
    int cnt, need, lo, hi, best, thr, x, j, m, p;
    logic [31:0] bt, h;
    logic [30:0] grp;
    group_count = group_count + 23'd1;
    need = r.voices_needed;
    lo = r.range_low;
    hi = (r.range_high > NV) ? NV : r.range_high;
    cnt = 0;
    if (need == 0 || need > MG) begin
      expected_words.push_back(make_word(vast_pkg::RES_NO_VOICES, 0, 0, 0, 0, 1));
      return;
    end
    for (int a = 0; a < need; a++) begin
      best = -1;
      bt = 32'hFFFF_FFFF;
      for (int v = lo; v < hi; v++)
        if (v_status[v] == vast_pkg::ST_FREE && !in_list(pk, cnt, v) && v_stamp[v] < bt) begin
          bt = v_stamp[v];
          best = v;
        end
      if (best >= 0) begin
        pk[cnt] = best;
        cnt++;
      end
    end
    while (cnt < need) begin
      thr = cfg_steal_equal ? int'(r.priority_req) : int'(r.priority_req) - 1;
      best = -1;
      bt = 32'hFFFF_FFFF;
      for (int v = lo; v < hi; v++) begin
        p = v_prio[v];
        if (!in_list(pk, cnt, v) && p <= vast_pkg::STEAL_LIMIT) begin
          if (p < thr) begin
            thr = p;
            bt = v_stamp[v];
            best = v;
          end else if (p == thr && v_stamp[v] < bt) begin
            bt = v_stamp[v];
            best = v;
          end
        end
      end
      if (best < 0) break;
      pk[cnt] = best;
      cnt++;
    end
    if (cnt != need) begin
      expected_words.push_back(make_word(vast_pkg::RES_NO_VOICES, 0, 0, 0, 0, 1));
      return;
    end
    for (int k = 1; k < need; k++) begin
      x = pk[k];
      j = k;
      while (j > 0 && pk[j-1] > x) begin
        pk[j] = pk[j-1];
        j--;
      end
      pk[j] = x;
    end
    for (int k = 0; k < need; k++) begin
      stopv[k] = (v_status[pk[k]] != vast_pkg::ST_FREE);
      stoph[k] = '0;
      if (stopv[k]) begin
        h = v_handle[pk[k]];
        m = v_master[pk[k]];
        if (h[31] && m >= 0 && m < NV) h = v_handle[m];
        stoph[k] = h;
      end
    end
    grp = {group_count, 8'(pk[0])};
    for (int k = 0; k < need; k++) begin
      v_status[pk[k]] = vast_pkg::ST_PLAY;
      v_stamp[pk[k]] = r.audio_tick;
      v_prio[pk[k]] = r.priority_req;
      v_handle[pk[k]] = (k == 0) ? {1'b0, grp} : 32'hFFFF_FFFF;
      v_master[pk[k]] = (k == 0) ? -1 : pk[0];
    end
    live_handles.push_back({1'b0, grp});
    if (live_handles.size() > 16) void'(live_handles.pop_front());
    for (int k = 0; k < need; k++)
      expected_words.push_back(make_word(vast_pkg::RES_OK, 6'(pk[k]), grp, stopv[k],
                                         stoph[k], k == need - 1));
  endfunction

  function automatic void predict_free(int vc, logic [31:0] tk);
    logic [15:0] key;
    int total, mv, n;
    key = v_patch[vc];
    total = (cfg_voices_total > NV) ? NV : cfg_voices_total;
    mv = -1;
    n = 0;
    if (key == 0) begin
      release_voice(vc, tk);
      return;
    end
    for (int i = 0; i < total; i++)
      if (v_patch[i] == key && !v_handle[i][31] && v_status[i] != vast_pkg::ST_FREE) begin
        n++;
        if (v_is_master[i]) mv = i;
      end
    if (n == 1) begin
      release_voice(vc, tk);
    end else if (mv >= 0 && v_status[mv] == vast_pkg::ST_HELD && vc != mv && n == 2) begin
      release_voice(vc, tk);
      release_voice(mv, tk);
    end else if (mv >= 0 && v_status[mv] == vast_pkg::ST_PLAY && vc == mv) begin
      v_status[mv] = vast_pkg::ST_HELD;
    end else begin
      release_voice(vc, tk);
    end
  endfunction

  function automatic void predict_word(vast_pkg::req_t r);
    logic [31:0] h;
    int v, total;
    case (r.cmd)
      vast_pkg::CMD_ALLOC: begin
        predict_alloc(r);
      end
      vast_pkg::CMD_FREE: begin
        predict_free(r.voice_index, r.audio_tick);
        expected_words.push_back(make_word(vast_pkg::RES_OK, r.voice_index, 0, 0, 0, 1));
      end
      vast_pkg::CMD_LOOKUP: begin
        h = r.lookup_handle;
        v = h[7:0];
        total = (cfg_voices_total > NV) ? NV : cfg_voices_total;
        if (!h[31] && v < total && v_status[v] != vast_pkg::ST_FREE && v_handle[v] == h)
          expected_words.push_back(make_word(vast_pkg::RES_OK, 6'(v), 0, 0, 0, 1));
        else
          expected_words.push_back(make_word(vast_pkg::RES_BAD_HANDLE, 0, 0, 0, 0, 1));
      end
      default: begin
        v_patch[r.voice_index] = r.patch_key;
        v_is_master[r.voice_index] = r.master_flag;
        expected_words.push_back(make_word(vast_pkg::RES_OK, r.voice_index, 0, 0, 0, 1));
      end
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) predict_word(req_data);
      if (!req_valid || req_ready) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle) begin
          req_data <= pending_words.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
    else if (hold_go) hold_left <= 600;
  end

  // monitor
  always @(posedge clk) begin
    vast_pkg::rsp_t e;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %p", rsp_data);
        end else begin
          e = expected_words.pop_front();
          if (rsp_data.status_code !== e.status_code || rsp_data.voice_out !== e.voice_out ||
              rsp_data.group_handle !== e.group_handle ||
              rsp_data.stop_valid !== e.stop_valid ||
              rsp_data.stop_handle !== e.stop_handle || rsp_data.last !== e.last) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, rsp_data);
          end
        end
      end
      rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == 3'd0) cfg_steal_equal = data[0];
    else cfg_voices_total = data[6:0];
  endtask

  task automatic drain();
    wait (pending_words.size() == 0 && !req_valid && expected_words.size() == 0);
    repeat (120) @(posedge clk);
  endtask

  function automatic vast_pkg::req_t cmd_word(logic [1:0] c, int need, int prio, int lo,
                                              int hi, int vi, logic [31:0] lh,
                                              logic [31:0] tk, int key, bit mf);
    vast_pkg::req_t r;
    r.cmd = c;
    r.voices_needed = 3'(need);
    r.priority_req = 8'(prio);
    r.range_low = 6'(lo);
    r.range_high = 7'(hi);
    r.voice_index = 6'(vi);
    r.lookup_handle = lh;
    r.audio_tick = tk;
    r.patch_key = 16'(key);
    r.master_flag = mf;
    return r;
  endfunction

  function automatic vast_pkg::req_t random_word();
    vast_pkg::req_t r;
    int k, lo, hi;
    logic [31:0] h;
    k = $urandom_range(99);
    tick_now = tick_now + $urandom_range(1, 50);
    lo = $urandom_range(0, 40);
    hi = lo + $urandom_range(1, 24);
    if ($urandom_range(9) == 0) hi = $urandom_range(0, 127);
    if (k < 10) begin
      r = cmd_word(2'($urandom_range(3)), $urandom_range(7), $urandom_range(255),
                   $urandom_range(63), $urandom_range(127), $urandom_range(63),
                   $urandom, $urandom, $urandom_range(65535), 1'($urandom_range(1)));
    end else if (k < 48) begin
      r = cmd_word(vast_pkg::CMD_ALLOC, ($urandom_range(19) == 0) ? 7 * $urandom_range(1) :
                   $urandom_range(1, MG),
                   ($urandom_range(4) == 0) ? $urandom_range(101, 255) : $urandom_range(0, 110),
                   lo, hi, 0, 0, tick_now, 0, 0);
    end else if (k < 68) begin
      r = cmd_word(vast_pkg::CMD_FREE, 1, 0, 0, 0, $urandom_range(63), 0,
                   ($urandom_range(9) == 0) ? 32'hFFFF_FFFF : tick_now, 0, 0);
    end else if (k < 82) begin
      h = (live_handles.size() > 0) ?
          live_handles[$urandom_range(live_handles.size() - 1)] : $urandom;
      if ($urandom_range(3) == 0) h = h ^ (32'd1 << $urandom_range(31));
      r = cmd_word(vast_pkg::CMD_LOOKUP, 1, 0, 0, 0, 0, h, tick_now, 0, 0);
    end else begin
      r = cmd_word(vast_pkg::CMD_TAG, 1, 0, 0, 0, $urandom_range(63), 0, tick_now,
                   $urandom_range(0, 3), 1'($urandom_range(1)));
    end
    return r;
  endfunction

  initial begin
    for (int i = 0; i < NV; i++) begin
      v_status[i] = vast_pkg::ST_FREE;
      v_stamp[i] = '0;
      v_prio[i] = '0;
      v_handle[i] = '0;
      v_master[i] = -1;
      v_patch[i] = '0;
      v_is_master[i] = 1'b0;
    end
    group_count = '0;
    cfg_steal_equal = 1'b0;
    cfg_voices_total = vast_pkg::VOICES_TOTAL_RST;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    cfg_write(3'd0, 32'd0);
    cfg_write(3'd4, 32'd64);

    // directed
    send_idle = 14;
    recv_idle = 69;
    pending_words.push_back(cmd_word(vast_pkg::CMD_ALLOC, 1, 50, 0, 64, 0, 0, 100, 0, 0));
    pending_words.push_back(cmd_word(vast_pkg::CMD_LOOKUP, 1, 0, 0, 0, 0, 32'h100, 0, 0, 0));
    pending_words.push_back(cmd_word(vast_pkg::CMD_LOOKUP, 1, 0, 0, 0, 0, 32'h8000_0100,
                                     0, 0, 0));
    pending_words.push_back(cmd_word(vast_pkg::CMD_ALLOC, 6, 255, 0, 127, 0, 0, 200, 0, 0));
    pending_words.push_back(cmd_word(vast_pkg::CMD_ALLOC, 0, 10, 0, 64, 0, 0, 300, 0, 0));
    pending_words.push_back(cmd_word(vast_pkg::CMD_ALLOC, 7, 10, 0, 64, 0, 0, 300, 0, 0));
    pending_words.push_back(cmd_word(vast_pkg::CMD_ALLOC, 2, 10, 40, 10, 0, 0, 300, 0, 0));
    pending_words.push_back(cmd_word(vast_pkg::CMD_ALLOC, 2, 0, 63, 64, 0, 0, 300, 0, 0));
    pending_words.push_back(cmd_word(vast_pkg::CMD_FREE, 1, 0, 0, 0, 63, 0, 32'hFFFF_FFFF,
                                     0, 0));
    pending_words.push_back(cmd_word(vast_pkg::CMD_ALLOC, 1, 0, 62, 64, 0, 0, 400, 0, 0));
    pending_words.push_back(cmd_word(vast_pkg::CMD_ALLOC, 3, 100, 0, 4, 0, 0, 500, 0, 0));
    pending_words.push_back(cmd_word(vast_pkg::CMD_ALLOC, 3, 101, 0, 4, 0, 0, 600, 0, 0));
    pending_words.push_back(cmd_word(vast_pkg::CMD_TAG, 1, 0, 0, 0, 1, 0, 0, 16'hFFFF, 1));
    pending_words.push_back(cmd_word(vast_pkg::CMD_TAG, 1, 0, 0, 0, 0, 0, 0, 16'hFFFF, 0));
    pending_words.push_back(cmd_word(vast_pkg::CMD_FREE, 1, 0, 0, 0, 1, 0, 700, 0, 0));
    pending_words.push_back(cmd_word(vast_pkg::CMD_FREE, 1, 0, 0, 0, 0, 0, 32'hFFFF_FFFF,
                                     0, 0));
    pending_words.push_back(cmd_word(vast_pkg::CMD_FREE, 1, 0, 0, 0, 1, 0, 800, 0, 0));
    pending_words.push_back(cmd_word(vast_pkg::CMD_LOOKUP, 1, 0, 0, 0, 0, 32'h7FFF_FFFF,
                                     0, 0, 0));
    pending_words.push_back(cmd_word(vast_pkg::CMD_ALLOC, 6, 200, 0, 6, 0, 0, 32'hFFFF_FFFF,
                                     0, 0));
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 14 : (ph == 1) ? 69 : 0;
      recv_idle = (ph == 0) ? 69 : (ph == 1) ? 14 : 0;
      cfg_write(3'd0, (ph == 1) ? 32'd1 : 32'd0);
      cfg_write(3'd4, (ph == 0) ? 32'd1 : (ph == 1) ? 32'd37 : 32'd64);
      for (int n = 0; n < 135; n++) begin
        wait (pending_words.size() < 3);
        pending_words.push_back(random_word());
        if (n == 40) begin
          @(posedge clk);
          hold_go <= 1'b1;
          @(posedge clk);
          hold_go <= 1'b0;
        end
        if (n == 90) drain();
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
src/vast_pkg.sv
src/vast_dp.sv
src/vast_ctrl.sv
src/voice_allocator_with_stealing_top.sv
verif/voice_allocator_with_stealing_top_tb.sv
